// ----- hw/rtl/priority_ordered_slot_list_defines.svh -----
// assertion macros shared by the slot list rtl
`ifndef PRIORITY_ORDERED_SLOT_LIST_DEFINES_SVH
`define PRIORITY_ORDERED_SLOT_LIST_DEFINES_SVH
`ifndef ASSERT_OFF
`define POSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define POSL_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define POSL_ASSERT(lbl, clk, rst_n, prop, msg)
`define POSL_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/posl_pkg.sv -----
// shared types and constants of the priority ordered slot list
package posl_pkg;

    localparam int unsigned SLOTS_DEF = 32;
    localparam int unsigned ACTION_W  = 3;
    localparam int unsigned SLOT_W    = 5;
    localparam int unsigned PRIO_W    = 16;
    localparam int unsigned STATUS_W  = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_REPRIO = 3'd2,
        ACT_WALK   = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_UNUSED = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_INS_START,
        ST_INS_TAIL,
        ST_INS_CMP,
        ST_INS_HEAD,
        ST_INS_WALK,
        ST_LINK_RD,
        ST_LINK_PREV,
        ST_LINK_NEXT,
        ST_UNLINK,
        ST_WALK_HEAD,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } fs_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fs_stat_t;

endpackage

// ----- hw/rtl/posl_req_if.sv -----
// request channel of the slot list
interface posl_req_if;
    logic                            valid;
    logic                            ready;
    logic [posl_pkg::ACTION_W-1:0]   action;
    logic [posl_pkg::SLOT_W-1:0]     slot;
    logic [posl_pkg::PRIO_W-1:0]     priority_req;

    modport source (output valid, action, slot, priority_req, input ready);
    modport sink (input valid, action, slot, priority_req, output ready);
endinterface

// ----- hw/rtl/posl_rsp_if.sv -----
// result channel of the slot list
interface posl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [posl_pkg::SLOT_W-1:0]     slot_out;
    logic [posl_pkg::STATUS_W-1:0]   status;
    logic                            last;

    modport source (output valid, slot_out, status, last, input ready);
    modport sink (input valid, slot_out, status, last, output ready);
endinterface

// ----- hw/rtl/posl_link_ram.sv -----
// one link memory of the ring, one read and one write port, sentinel reset value
module posl_link_ram #(
    parameter int unsigned SLOTS = posl_pkg::SLOTS_DEF,
    localparam int unsigned NW = $clog2(SLOTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [NW-1:0] rd_addr,
    output logic [NW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [NW-1:0] wr_addr,
    input  logic [NW-1:0] wr_data
);

    localparam logic [NW-1:0] SENT = NW'(SLOTS);

    logic [NW-1:0] link_mem [SLOTS + 1];
    logic [SLOTS:0] vld_reg;
    logic [NW-1:0] rd_data_reg;

    // entries never written read as a link to the sentinel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? link_mem[rd_addr] : SENT;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/posl_free_stack.sv -----
// free slot stack with its top counter
module posl_free_stack #(
    parameter int unsigned SLOTS = posl_pkg::SLOTS_DEF,
    localparam int unsigned SW = $clog2(SLOTS),
    localparam int unsigned NW = $clog2(SLOTS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  posl_pkg::fs_ctrl_t ctrl,
    input  logic [SW-1:0]      push_slot,
    output logic [SW-1:0]      rd_slot,
    output logic [NW-1:0]      count,
    output posl_pkg::fs_stat_t stat
);

    logic [SW-1:0] stack_mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    logic [NW-1:0] top_reg;
    logic [SW-1:0] rd_slot_reg;
    logic [SW-1:0] rd_idx;
    logic [SW-1:0] wr_idx;
    logic          push_ok;

    assign rd_idx  = SW'(top_reg);
    assign wr_idx  = SW'(top_reg - NW'(1));
    assign push_ok = ctrl.push && (top_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            vld_reg <= '0;
        end
        else if (ctrl.pop)
        begin
            top_reg <= top_reg + NW'(1);
        end
        else if (push_ok)
        begin
            top_reg         <= top_reg - NW'(1);
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    // an entry never pushed still holds its own index
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            stack_mem[wr_idx] <= push_slot;
        end
        if (ctrl.rd)
        begin
            rd_slot_reg <= vld_reg[rd_idx] ? stack_mem[rd_idx] : rd_idx;
        end
    end

    assign rd_slot    = rd_slot_reg;
    assign count      = top_reg;
    assign stat.full  = (top_reg == NW'(SLOTS));
    assign stat.empty = (top_reg == '0);

endmodule

// ----- hw/rtl/priority_ordered_slot_list.sv -----
// top level: sequencer, priority memory and slot flags of the priority ordered slot list
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | action, slot, priority_req
//  rsp     | out | valid / ready | slot_out, status, last
//
// one request at a time; create and change priority link the entry directly when appended
// and after an ordered search, one entry passed per step, when it goes ahead of the tail
// delete unlinks and frees the slot, walk and delete all go slot by slot, errors respond directly
// the single read port of each link memory sets the pace, one list step a cycle when not held
// asynchronous reset; unwritten link and stack entries read as their reset contents
// a full result register holds the sequencer; a new request is taken while one waits

`include "priority_ordered_slot_list_defines.svh"

module priority_ordered_slot_list #(
    parameter int unsigned SLOTS = posl_pkg::SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    posl_req_if.sink          req,
    posl_rsp_if.source        rsp
);

    localparam int unsigned SW = $clog2(SLOTS);
    localparam int unsigned NW = $clog2(SLOTS + 1);
    localparam int unsigned CW = (NW > posl_pkg::SLOT_W) ? NW : posl_pkg::SLOT_W;
    localparam logic [NW-1:0] SENT = NW'(SLOTS);

    posl_pkg::state_t  state_reg, state_next;
    posl_pkg::action_t act_reg, act_next;
    logic [posl_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic [NW-1:0] s_reg, s_next;
    logic [NW-1:0] at_reg, at_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [posl_pkg::SLOT_W-1:0] resp_slot_reg, resp_slot_next;
    posl_pkg::status_t resp_status_reg, resp_status_next;

    logic [SLOTS-1:0] in_use_reg;
    logic use_set;
    logic use_clr;
    logic [SW-1:0] use_idx;

    logic [posl_pkg::PRIO_W-1:0] prio_mem [SLOTS];
    logic [posl_pkg::PRIO_W-1:0] pr_rdata_reg;
    logic pr_rd_en;
    logic [SW-1:0] pr_rd_addr;
    logic prio_we;
    logic [SW-1:0] prio_waddr;
    logic [posl_pkg::PRIO_W-1:0] prio_wdata;

    logic nx_rd_en, nx_wr_en;
    logic [NW-1:0] nx_rd_addr, nx_rdata, nx_wr_addr, nx_wr_data;
    logic pv_rd_en, pv_wr_en;
    logic [NW-1:0] pv_rd_addr, pv_rdata, pv_wr_addr, pv_wr_data;

    posl_pkg::fs_ctrl_t fs_ctrl;
    posl_pkg::fs_stat_t fs_stat;
    logic [NW-1:0] fs_count;
    logic [SW-1:0] fs_rdata;
    logic [SW-1:0] fs_push_slot;

    logic out_valid_reg;
    logic [posl_pkg::SLOT_W-1:0] out_slot_reg;
    logic [posl_pkg::STATUS_W-1:0] out_status_reg;
    logic out_last_reg;
    logic rsp_load;
    logic [posl_pkg::SLOT_W-1:0] rsp_slot_next;
    posl_pkg::status_t rsp_status_next;
    logic rsp_last_next;
    logic rsp_free;

    logic req_fire;
    logic slot_ok;
    logic [SW-1:0] req_idx;

    posl_link_ram #(.SLOTS(SLOTS)) u_next_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (nx_rd_en),
        .rd_addr (nx_rd_addr),
        .rd_data (nx_rdata),
        .wr_en   (nx_wr_en),
        .wr_addr (nx_wr_addr),
        .wr_data (nx_wr_data)
    );

    posl_link_ram #(.SLOTS(SLOTS)) u_prev_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pv_rd_en),
        .rd_addr (pv_rd_addr),
        .rd_data (pv_rdata),
        .wr_en   (pv_wr_en),
        .wr_addr (pv_wr_addr),
        .wr_data (pv_wr_data)
    );

    posl_free_stack #(.SLOTS(SLOTS)) u_free_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fs_ctrl),
        .push_slot (fs_push_slot),
        .rd_slot   (fs_rdata),
        .count     (fs_count),
        .stat      (fs_stat)
    );

    assign req.ready = (state_reg == posl_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign slot_ok   = CW'(req.slot) < CW'(SLOTS);
    assign req_idx   = SW'(req.slot);
    assign rsp_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        prio_next        = prio_reg;
        s_next           = s_reg;
        at_next          = at_reg;
        cur_next         = cur_reg;
        resp_slot_next   = resp_slot_reg;
        resp_status_next = resp_status_reg;

        use_set      = 1'b0;
        use_clr      = 1'b0;
        use_idx      = SW'(s_reg);
        pr_rd_en     = 1'b0;
        pr_rd_addr   = SW'(cur_reg);
        prio_we      = 1'b0;
        prio_waddr   = SW'(s_reg);
        prio_wdata   = prio_reg;
        nx_rd_en     = 1'b0;
        nx_rd_addr   = SENT;
        nx_wr_en     = 1'b0;
        nx_wr_addr   = SENT;
        nx_wr_data   = SENT;
        pv_rd_en     = 1'b0;
        pv_rd_addr   = SENT;
        pv_wr_en     = 1'b0;
        pv_wr_addr   = SENT;
        pv_wr_data   = SENT;
        fs_ctrl      = '0;
        fs_push_slot = SW'(s_reg);

        rsp_load        = 1'b0;
        rsp_slot_next   = resp_slot_reg;
        rsp_status_next = resp_status_reg;
        rsp_last_next   = 1'b1;

        case (state_reg)
            posl_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    act_next  = posl_pkg::action_t'(req.action);
                    prio_next = req.priority_req;
                    case (req.action)
                        posl_pkg::ACT_CREATE:
                        begin
                            if (fs_stat.full)
                            begin
                                resp_slot_next   = '0;
                                resp_status_next = posl_pkg::STAT_FULL;
                                state_next       = posl_pkg::ST_RESP;
                            end
                            else
                            begin
                                fs_ctrl.rd = 1'b1;
                                state_next = posl_pkg::ST_POP;
                            end
                        end
                        posl_pkg::ACT_DELETE, posl_pkg::ACT_REPRIO:
                        begin
                            resp_slot_next = req.slot;
                            if (!(slot_ok && in_use_reg[req_idx]))
                            begin
                                resp_status_next = posl_pkg::STAT_UNUSED;
                                state_next       = posl_pkg::ST_RESP;
                            end
                            else
                            begin
                                s_next     = NW'(req.slot);
                                nx_rd_en   = 1'b1;
                                nx_rd_addr = NW'(req.slot);
                                pv_rd_en   = 1'b1;
                                pv_rd_addr = NW'(req.slot);
                                if (req.action == posl_pkg::ACT_REPRIO)
                                begin
                                    prio_we    = 1'b1;
                                    prio_waddr = req_idx;
                                    prio_wdata = req.priority_req;
                                end
                                state_next = posl_pkg::ST_UNLINK;
                            end
                        end
                        posl_pkg::ACT_WALK, posl_pkg::ACT_CLEAR:
                        begin
                            if (fs_stat.empty)
                            begin
                                resp_slot_next   = '0;
                                resp_status_next = posl_pkg::STAT_EMPTY;
                                state_next       = posl_pkg::ST_RESP;
                            end
                            else
                            begin
                                nx_rd_en   = 1'b1;
                                nx_rd_addr = SENT;
                                state_next = posl_pkg::ST_WALK_HEAD;
                            end
                        end
                        default:
                        begin
                            state_next = posl_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            posl_pkg::ST_POP:
            begin
                s_next      = NW'(fs_rdata);
                prio_we     = 1'b1;
                prio_waddr  = fs_rdata;
                prio_wdata  = prio_reg;
                use_set     = 1'b1;
                use_idx     = fs_rdata;
                fs_ctrl.pop = 1'b1;
                state_next  = posl_pkg::ST_INS_START;
            end

            posl_pkg::ST_INS_START:
            begin
                pv_rd_en   = 1'b1;
                pv_rd_addr = SENT;
                state_next = posl_pkg::ST_INS_TAIL;
            end

            posl_pkg::ST_INS_TAIL:
            begin
                if (pv_rdata == SENT)
                begin
                    at_next    = SENT;
                    state_next = posl_pkg::ST_LINK_RD;
                end
                else
                begin
                    pr_rd_en   = 1'b1;
                    pr_rd_addr = SW'(pv_rdata);
                    state_next = posl_pkg::ST_INS_CMP;
                end
            end

            posl_pkg::ST_INS_CMP:
            begin
                // equal priorities go behind the tail
                if (pr_rdata_reg <= prio_reg)
                begin
                    at_next    = SENT;
                    state_next = posl_pkg::ST_LINK_RD;
                end
                else
                begin
                    nx_rd_en   = 1'b1;
                    nx_rd_addr = SENT;
                    state_next = posl_pkg::ST_INS_HEAD;
                end
            end

            posl_pkg::ST_INS_HEAD:
            begin
                cur_next   = nx_rdata;
                nx_rd_en   = 1'b1;
                nx_rd_addr = nx_rdata;
                pr_rd_en   = (nx_rdata != SENT);
                pr_rd_addr = SW'(nx_rdata);
                state_next = posl_pkg::ST_INS_WALK;
            end

            posl_pkg::ST_INS_WALK:
            begin
                // link and priority of cur arrive together; next step read is issued at once
                if (cur_reg == SENT || pr_rdata_reg > prio_reg)
                begin
                    at_next    = cur_reg;
                    state_next = posl_pkg::ST_LINK_RD;
                end
                else
                begin
                    cur_next   = nx_rdata;
                    nx_rd_en   = 1'b1;
                    nx_rd_addr = nx_rdata;
                    pr_rd_en   = (nx_rdata != SENT);
                    pr_rd_addr = SW'(nx_rdata);
                end
            end

            posl_pkg::ST_LINK_RD:
            begin
                pv_rd_en   = 1'b1;
                pv_rd_addr = at_reg;
                state_next = posl_pkg::ST_LINK_PREV;
            end

            posl_pkg::ST_LINK_PREV:
            begin
                nx_wr_en   = 1'b1;
                nx_wr_addr = pv_rdata;
                nx_wr_data = s_reg;
                pv_wr_en   = 1'b1;
                pv_wr_addr = s_reg;
                pv_wr_data = pv_rdata;
                state_next = posl_pkg::ST_LINK_NEXT;
            end

            posl_pkg::ST_LINK_NEXT:
            begin
                pv_wr_en         = 1'b1;
                pv_wr_addr       = at_reg;
                pv_wr_data       = s_reg;
                nx_wr_en         = 1'b1;
                nx_wr_addr       = s_reg;
                nx_wr_data       = at_reg;
                resp_slot_next   = posl_pkg::SLOT_W'(s_reg);
                resp_status_next = posl_pkg::STAT_OK;
                state_next       = posl_pkg::ST_RESP;
            end

            posl_pkg::ST_UNLINK:
            begin
                nx_wr_en   = 1'b1;
                nx_wr_addr = pv_rdata;
                nx_wr_data = nx_rdata;
                pv_wr_en   = 1'b1;
                pv_wr_addr = nx_rdata;
                pv_wr_data = pv_rdata;
                if (act_reg == posl_pkg::ACT_DELETE)
                begin
                    use_clr          = 1'b1;
                    use_idx          = SW'(s_reg);
                    fs_ctrl.push     = 1'b1;
                    fs_push_slot     = SW'(s_reg);
                    resp_status_next = posl_pkg::STAT_OK;
                    state_next       = posl_pkg::ST_RESP;
                end
                else
                begin
                    state_next = posl_pkg::ST_INS_START;
                end
            end

            posl_pkg::ST_WALK_HEAD:
            begin
                cur_next   = nx_rdata;
                nx_rd_en   = 1'b1;
                nx_rd_addr = nx_rdata;
                state_next = posl_pkg::ST_WALK;
            end

            posl_pkg::ST_WALK:
            begin
                // nx_rdata is the successor of cur; it is held while the result register is full
                if (rsp_free)
                begin
                    rsp_load        = 1'b1;
                    rsp_slot_next   = posl_pkg::SLOT_W'(cur_reg);
                    rsp_status_next = posl_pkg::STAT_OK;
                    rsp_last_next   = (nx_rdata == SENT);
                    if (act_reg == posl_pkg::ACT_CLEAR)
                    begin
                        // cur is always the head here, so its predecessor is the sentinel
                        nx_wr_en     = 1'b1;
                        nx_wr_addr   = SENT;
                        nx_wr_data   = nx_rdata;
                        pv_wr_en     = 1'b1;
                        pv_wr_addr   = nx_rdata;
                        pv_wr_data   = SENT;
                        use_clr      = 1'b1;
                        use_idx      = SW'(cur_reg);
                        fs_ctrl.push = 1'b1;
                        fs_push_slot = SW'(cur_reg);
                    end
                    if (nx_rdata == SENT)
                    begin
                        state_next = posl_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cur_next   = nx_rdata;
                        nx_rd_en   = 1'b1;
                        nx_rd_addr = nx_rdata;
                    end
                end
            end

            posl_pkg::ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_load        = 1'b1;
                    rsp_slot_next   = resp_slot_reg;
                    rsp_status_next = resp_status_reg;
                    rsp_last_next   = 1'b1;
                    state_next      = posl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = posl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= posl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        prio_reg        <= prio_next;
        s_reg           <= s_next;
        at_reg          <= at_next;
        cur_reg         <= cur_next;
        resp_slot_reg   <= resp_slot_next;
        resp_status_reg <= resp_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else if (use_set)
        begin
            in_use_reg[use_idx] <= 1'b1;
        end
        else if (use_clr)
        begin
            in_use_reg[use_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prio_we)
        begin
            prio_mem[prio_waddr] <= prio_wdata;
        end
        if (pr_rd_en)
        begin
            pr_rdata_reg <= prio_mem[pr_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_slot_reg   <= rsp_slot_next;
            out_status_reg <= rsp_status_next;
            out_last_reg   <= rsp_last_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.slot_out = out_slot_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.last     = out_last_reg;

    `POSL_ASSERT(a_count_matches_use, clk, rst_n, $countones(in_use_reg) == int'(fs_count), "slot flags disagree with free stack depth")
    `POSL_ASSERT(a_walk_not_sentinel, clk, rst_n, (state_reg == posl_pkg::ST_WALK) |-> (cur_reg != SENT), "walk reached the sentinel")
    `POSL_ASSERT(a_walk_emits_used, clk, rst_n, (state_reg == posl_pkg::ST_WALK && rsp_load) |-> in_use_reg[SW'(cur_reg)], "walk emitted a free slot")
    `POSL_ASSERT(a_last_ends_request, clk, rst_n, (rsp_load && rsp_last_next) |=> (state_reg == posl_pkg::ST_IDLE), "final result did not end the request")
    `POSL_NEVER(a_no_pop_when_full, clk, rst_n, fs_ctrl.pop && fs_stat.full, "pop from an exhausted free stack")

endmodule
